### rtl/core/tspat_pkg.sv
// Package for the PAT section parser: request and response types, codes and constants.
// Used by ts_pat_section_parser, tspat_ctrl and tspat_dp; depends on nothing.
`default_nettype none
package tspat_pkg;

    localparam int MAX_PROGRAMS_DEF = 256;
    localparam int PID_SPACE_DEF    = 8192;

    localparam logic [7:0]  TABLE_ID_PAT = 8'h00;
    localparam logic [11:0] LEN_MIN      = 12'd9;
    localparam logic [11:0] LEN_MAX      = 12'd1021;
    localparam logic [10:0] IDX_SAT      = 11'd2047;
    localparam logic [8:0]  STAGED_SAT   = 9'd511;

    localparam logic [1:0] KIND_PROGRAM = 2'd0;
    localparam logic [1:0] KIND_NIT     = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_QUERY   = 2'd3;

    localparam logic [2:0] STAT_COMMITTED   = 3'd0;
    localparam logic [2:0] STAT_NOT_CURRENT = 3'd1;
    localparam logic [2:0] STAT_SAME_VER    = 3'd2;
    localparam logic [2:0] STAT_BAD_HEADER  = 3'd3;
    localparam logic [2:0] STAT_TRUNCATED   = 3'd4;
    localparam logic [2:0] STAT_MULTI_SECT  = 3'd5;
    localparam logic [2:0] STAT_MISALIGNED  = 3'd6;

    localparam logic [1:0] CLASS_UNKNOWN = 2'd0;
    localparam logic [1:0] CLASS_PSI     = 2'd1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  data_byte;
        logic        last;
        logic [12:0] query_pid;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] prog_num;
        logic [12:0] pid;
        logic [2:0]  status;
        logic [15:0] stream_id;
        logic [4:0]  version;
        logic [7:0]  program_count;
        logic [31:0] crc_word;
        logic [1:0]  pid_class;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_QUERY,
        ST_WALK_CLR,
        ST_WALK_SET,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic sweep_step;
        logic byte_step;
        logic query_load;
        logic walk_clr_step;
        logic walk_to_set;
        logic walk_set_step;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic commit;
        logic sweep_last;
        logic clr_done;
        logic set_done;
    } status_t;

endpackage
`default_nettype wire

### rtl/core/ts_pat_section_parser.sv
// PAT section parser: one section byte or one PID class query per request.
// Entry-ending and last bytes register a response in the cycle after acceptance; queries go
// via the map RAM read and ST_QUERY. One byte per cycle while req_stall is low. A committing
// last byte starts a walk (clear old PIDs, set new ones, drain). A sweep after reset zeroes
// the PID class map before requests are taken. Depends on tspat_pkg, tspat_ctrl and tspat_dp.
`default_nettype none
module ts_pat_section_parser #(
    parameter int MAX_PROGRAMS = tspat_pkg::MAX_PROGRAMS_DEF,
    parameter int PID_SPACE    = tspat_pkg::PID_SPACE_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire tspat_pkg::req_t req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output tspat_pkg::rsp_t      rsp
);
    import tspat_pkg::*;

    cmd_t    cmd;
    status_t stat;

    tspat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (req.mode),
        .stat      (stat),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    tspat_dp #(.MAX_PROGRAMS(MAX_PROGRAMS), .PID_SPACE(PID_SPACE)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );
endmodule
`default_nettype wire

### rtl/core/tspat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module tspat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/core/tspat_ctrl.sv
// Controller state machine of the PAT section parser.
// Depends on tspat_pkg; drives commands to tspat_dp and reads its status.
`default_nettype none
module tspat_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_mode,
    input  wire tspat_pkg::status_t stat,
    output tspat_pkg::cmd_t        cmd,
    output logic                   req_stall
);
    import tspat_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_stall = !stat.out_free;
                if (req_valid && stat.out_free)
                begin
                    if (req_mode)
                    begin
                        state_next = ST_QUERY;
                    end
                    else
                    begin
                        cmd.byte_step = 1'b1;
                        if (stat.commit)
                        begin
                            state_next = ST_WALK_CLR;
                        end
                    end
                end
            end
            ST_QUERY:
            begin
                cmd.query_load = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_WALK_CLR:
            begin
                if (stat.clr_done)
                begin
                    cmd.walk_to_set = 1'b1;
                    state_next      = ST_WALK_SET;
                end
                else
                begin
                    cmd.walk_clr_step = 1'b1;
                end
            end
            ST_WALK_SET:
            begin
                if (stat.set_done)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.walk_set_step = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> req_stall)
        else $error("request taken while the controller is busy");
    a_query_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QUERY) |=> (state_reg == ST_IDLE))
        else $error("query answer did not return to idle");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK_SET && stat.set_done) |=> (state_reg == ST_DRAIN))
        else $error("commit walk ended without draining the last write");
    a_commit_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.byte_step && stat.commit) |=> (state_reg == ST_WALK_CLR))
        else $error("commit did not start the walk");
`endif
endmodule
`default_nettype wire

### rtl/core/tspat_dp.sv
// Datapath of the PAT section parser: header and entry decoding, tables, PID class map.
// Depends on tspat_pkg and tspat_ram; commanded by tspat_ctrl.
`default_nettype none
module tspat_dp #(
    parameter int MAX_PROGRAMS = tspat_pkg::MAX_PROGRAMS_DEF,
    parameter int PID_SPACE    = tspat_pkg::PID_SPACE_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tspat_pkg::req_t    req,
    input  wire tspat_pkg::cmd_t    cmd,
    output tspat_pkg::status_t      stat,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output tspat_pkg::rsp_t         rsp
);
    import tspat_pkg::*;

    localparam int AW = (MAX_PROGRAMS > 1) ? $clog2(MAX_PROGRAMS) : 1;
    localparam int CW = $clog2(MAX_PROGRAMS + 1);
    localparam int SW = $clog2(PID_SPACE);

    logic [10:0] idx_reg, idx_next;
    logic [11:0] len_reg, len_next;
    logic [15:0] sid_reg, sid_next;
    logic [4:0]  ver_reg, ver_next;
    logic        cur_reg, cur_next;
    logic [23:0] shift_reg, shift_next;
    logic [8:0]  staged_reg, staged_next;
    logic [2:0]  fault_reg, fault_next;
    logic [31:0] crc_reg, crc_next;

    logic [CW-1:0] active_cnt_reg, commit_n_reg, walk_idx_reg;
    logic          have_reg;
    logic [4:0]    aver_reg;
    logic [SW-1:0] sweep_reg;
    logic          pend_clr_reg, pend_set_reg;
    logic [AW-1:0] pend_idx_reg;

    logic          rsp_valid_reg;
    rsp_t          rsp_reg, byte_rsp, query_rsp;

    logic [7:0]  b;
    logic [12:0] total, idx4;
    logic        entry, emit;
    logic [15:0] pn;
    logic [12:0] epid;
    logic        stage_we;
    logic [11:0] count;
    logic        trunc;
    logic [2:0]  verdict;
    logic [CW-1:0] n_commit;

    logic [28:0] active_rd, staged_rd;
    logic [1:0]  map_rd;
    logic        map_we;
    logic [SW-1:0] map_waddr;
    logic [1:0]  map_wdata;

    assign b = req.data_byte;
    assign pn = shift_reg[23:8];
    assign epid = {shift_reg[4:0], b};
    assign total = {1'b0, len_reg} + 13'd3;
    assign idx4 = {2'b0, idx_reg} + 13'd4;

    always_comb
    begin
        idx_next    = (idx_reg < IDX_SAT) ? idx_reg + 11'd1 : idx_reg;
        len_next    = len_reg;
        sid_next    = sid_reg;
        ver_next    = ver_reg;
        cur_next    = cur_reg;
        shift_next  = shift_reg;
        staged_next = staged_reg;
        fault_next  = fault_reg;
        crc_next    = crc_reg;
        entry       = 1'b0;
        if (idx_reg == 11'd0)
        begin
            if (b != TABLE_ID_PAT)
            begin
                fault_next = STAT_BAD_HEADER;
            end
        end
        else if (idx_reg == 11'd1)
        begin
            if (!b[7] && fault_reg == STAT_COMMITTED)
            begin
                fault_next = STAT_BAD_HEADER;
            end
            len_next = {b[3:0], len_reg[7:0]};
        end
        else if (idx_reg == 11'd2)
        begin
            len_next = {len_reg[11:8], b};
            if (fault_reg == STAT_COMMITTED)
            begin
                if (len_next < LEN_MIN || len_next > LEN_MAX)
                begin
                    fault_next = STAT_BAD_HEADER;
                end
                else if (len_next[1:0] != LEN_MIN[1:0])
                begin
                    fault_next = STAT_MISALIGNED;
                end
            end
        end
        else if (idx_reg == 11'd3)
        begin
            sid_next = {b, sid_reg[7:0]};
        end
        else if (idx_reg == 11'd4)
        begin
            sid_next = {sid_reg[15:8], b};
        end
        else if (idx_reg == 11'd5)
        begin
            ver_next = b[5:1];
            cur_next = b[0];
        end
        else if (idx_reg == 11'd6 || idx_reg == 11'd7)
        begin
            if (b != 8'd0 && (fault_reg == STAT_COMMITTED || fault_reg == STAT_MISALIGNED))
            begin
                fault_next = STAT_MULTI_SECT;
            end
        end
        else if (fault_reg != STAT_BAD_HEADER)
        begin
            if (idx4 < total)
            begin
                if (idx_reg[1:0] == 2'd3)
                begin
                    entry      = 1'b1;
                    shift_next = '0;
                    if (pn != 16'd0 && staged_reg < STAGED_SAT)
                    begin
                        staged_next = staged_reg + 9'd1;
                    end
                end
                else
                begin
                    shift_next = {shift_reg[15:0], b};
                end
            end
            else if ({2'b0, idx_reg} < total)
            begin
                crc_next = {crc_reg[23:0], b};
            end
        end
    end

    assign emit = entry && fault_reg == STAT_COMMITTED && !req.last;
    assign stage_we = cmd.byte_step && entry && pn != 16'd0
                      && staged_reg < 9'(MAX_PROGRAMS);

    assign count = {1'b0, idx_reg} + 12'd1;
    assign trunc = count < 12'd3 || {1'b0, count} < ({1'b0, len_next} + 13'd3);

    always_comb
    begin
        if (fault_next == STAT_BAD_HEADER)
        begin
            verdict = STAT_BAD_HEADER;
        end
        else if (trunc)
        begin
            verdict = STAT_TRUNCATED;
        end
        else if (fault_next != STAT_COMMITTED)
        begin
            verdict = fault_next;
        end
        else if (!cur_next)
        begin
            verdict = STAT_NOT_CURRENT;
        end
        else if (have_reg && aver_reg == ver_next)
        begin
            verdict = STAT_SAME_VER;
        end
        else
        begin
            verdict = STAT_COMMITTED;
        end
    end

    assign n_commit = (staged_next > 9'(MAX_PROGRAMS)) ? CW'(MAX_PROGRAMS)
                                                       : CW'(staged_next);

    always_comb
    begin
        byte_rsp = '0;
        if (req.last)
        begin
            byte_rsp.kind          = KIND_DONE;
            byte_rsp.status        = verdict;
            byte_rsp.stream_id     = sid_next;
            byte_rsp.version       = ver_next;
            byte_rsp.program_count = staged_next[7:0];
            byte_rsp.crc_word      = crc_next;
        end
        else
        begin
            byte_rsp.kind     = (pn == 16'd0) ? KIND_NIT : KIND_PROGRAM;
            byte_rsp.prog_num = pn;
            byte_rsp.pid      = epid;
        end
    end

    always_comb
    begin
        query_rsp           = '0;
        query_rsp.kind      = KIND_QUERY;
        query_rsp.pid_class = map_rd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            len_reg        <= '0;
            sid_reg        <= '0;
            ver_reg        <= '0;
            cur_reg        <= 1'b0;
            shift_reg      <= '0;
            staged_reg     <= '0;
            fault_reg      <= '0;
            crc_reg        <= '0;
            active_cnt_reg <= '0;
            commit_n_reg   <= '0;
            walk_idx_reg   <= '0;
            have_reg       <= 1'b0;
            aver_reg       <= '0;
            sweep_reg      <= '0;
            pend_clr_reg   <= 1'b0;
            pend_set_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.byte_step)
            begin
                if (req.last)
                begin
                    idx_reg    <= '0;
                    len_reg    <= '0;
                    sid_reg    <= '0;
                    ver_reg    <= '0;
                    cur_reg    <= 1'b0;
                    shift_reg  <= '0;
                    staged_reg <= '0;
                    fault_reg  <= '0;
                    crc_reg    <= '0;
                    if (verdict == STAT_COMMITTED)
                    begin
                        commit_n_reg <= n_commit;
                        aver_reg     <= ver_next;
                        have_reg     <= 1'b1;
                        walk_idx_reg <= '0;
                    end
                end
                else
                begin
                    idx_reg    <= idx_next;
                    len_reg    <= len_next;
                    sid_reg    <= sid_next;
                    ver_reg    <= ver_next;
                    cur_reg    <= cur_next;
                    shift_reg  <= shift_next;
                    staged_reg <= staged_next;
                    fault_reg  <= fault_next;
                    crc_reg    <= crc_next;
                end
            end
            if (cmd.sweep_step)
            begin
                sweep_reg <= sweep_reg + SW'(1);
            end
            if (cmd.walk_to_set)
            begin
                walk_idx_reg   <= '0;
                active_cnt_reg <= commit_n_reg;
            end
            else if (cmd.walk_clr_step || cmd.walk_set_step)
            begin
                walk_idx_reg <= walk_idx_reg + CW'(1);
            end
            pend_clr_reg <= cmd.walk_clr_step;
            pend_set_reg <= cmd.walk_set_step;
            if ((cmd.byte_step && (emit || req.last)) || cmd.query_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= walk_idx_reg[AW-1:0];
        if (cmd.byte_step)
        begin
            rsp_reg <= byte_rsp;
        end
        else if (cmd.query_load)
        begin
            rsp_reg <= query_rsp;
        end
    end

    assign map_we    = cmd.sweep_step || pend_clr_reg || pend_set_reg;
    assign map_waddr = cmd.sweep_step ? sweep_reg
                     : (pend_clr_reg ? active_rd[SW-1:0] : staged_rd[SW-1:0]);
    assign map_wdata = (pend_set_reg && !cmd.sweep_step) ? CLASS_PSI : CLASS_UNKNOWN;

    tspat_ram #(.WIDTH(2), .DEPTH(PID_SPACE), .AW(SW)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (req.query_pid[SW-1:0]),
        .rdata (map_rd)
    );

    tspat_ram #(.WIDTH(29), .DEPTH(MAX_PROGRAMS), .AW(AW)) u_staged (
        .clk   (clk),
        .we    (stage_we),
        .waddr (staged_reg[AW-1:0]),
        .wdata ({pn, epid}),
        .raddr (walk_idx_reg[AW-1:0]),
        .rdata (staged_rd)
    );

    tspat_ram #(.WIDTH(29), .DEPTH(MAX_PROGRAMS), .AW(AW)) u_active (
        .clk   (clk),
        .we    (pend_set_reg),
        .waddr (pend_idx_reg),
        .wdata (staged_rd),
        .raddr (walk_idx_reg[AW-1:0]),
        .rdata (active_rd)
    );

    assign stat.out_free   = !rsp_valid_reg || !rsp_stall;
    assign stat.commit     = !req.mode && req.last && verdict == STAT_COMMITTED;
    assign stat.sweep_last = (sweep_reg == SW'(PID_SPACE - 1));
    assign stat.clr_done   = (walk_idx_reg >= active_cnt_reg);
    assign stat.set_done   = (walk_idx_reg >= commit_n_reg);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
endmodule
`default_nettype wire

### bench/ts_pat_section_parser_tb.sv
// Testbench for the PAT section parser: directed and random sections and PID class queries.
// Predicts every response with its own model of the parser; depends on tspat_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module ts_pat_section_parser_tb;
    import tspat_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    int send_idle_pct;
    int recv_idle_pct;
    int failures = 0;
    int stuck_cycles;

    rsp_t expected_rsps[$];

    logic [1:0]  class_map[0:8191];
    logic [28:0] active_tbl[0:255];
    logic [28:0] staged_tbl[0:255];
    int          active_cnt;
    bit          table_held;
    logic [4:0]  active_ver;
    int          byte_pos;
    logic [11:0] sect_len;
    logic [15:0] sect_tsid;
    logic [4:0]  sect_ver;
    logic        sect_cur;
    logic [23:0] entry_bytes;
    int          staged_cnt;
    logic [2:0]  fault;
    logic [31:0] crc_bytes;

    ts_pat_section_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic reset_section();
        byte_pos = 0;
        sect_len = '0;
        sect_tsid = '0;
        sect_ver = '0;
        sect_cur = 1'b0;
        entry_bytes = '0;
        staged_cnt = 0;
        fault = '0;
        crc_bytes = '0;
    endtask

    function automatic logic [2:0] section_verdict(int count);
        if (fault == STAT_BAD_HEADER)
            return STAT_BAD_HEADER;
        if (count < 3 || count < int'(sect_len) + 3)
            return STAT_TRUNCATED;
        if (fault != STAT_COMMITTED)
            return fault;
        if (!sect_cur)
            return STAT_NOT_CURRENT;
        if (table_held && active_ver == sect_ver)
            return STAT_SAME_VER;
        for (int i = 0; i < active_cnt; i++)
            class_map[active_tbl[i][12:0]] = CLASS_UNKNOWN;
        active_cnt = (staged_cnt < 256) ? staged_cnt : 256;
        for (int i = 0; i < active_cnt; i++)
        begin
            active_tbl[i] = staged_tbl[i];
            class_map[staged_tbl[i][12:0]] = CLASS_PSI;
        end
        active_ver = sect_ver;
        table_held = 1'b1;
        return STAT_COMMITTED;
    endfunction

    task automatic predict_request(input req_t r);
        rsp_t o;
        int   idx;
        int   total;
        logic [15:0] pn;
        logic [12:0] epid;
        bit   emit;
        o = '0;
        emit = 0;
        if (r.mode)
        begin
            o.kind = KIND_QUERY;
            o.pid_class = class_map[r.query_pid];
            expected_rsps.push_back(o);
            return;
        end
        idx = byte_pos;
        if (byte_pos < 2047)
            byte_pos++;
        case (idx)
            0: if (r.data_byte != TABLE_ID_PAT) fault = STAT_BAD_HEADER;
            1:
            begin
                if (!r.data_byte[7] && fault == STAT_COMMITTED)
                    fault = STAT_BAD_HEADER;
                sect_len[11:8] = r.data_byte[3:0];
            end
            2:
            begin
                sect_len[7:0] = r.data_byte;
                if (fault == STAT_COMMITTED)
                begin
                    if (sect_len < LEN_MIN || sect_len > LEN_MAX)
                        fault = STAT_BAD_HEADER;
                    else if (((sect_len - 12'd9) & 12'd3) != 0)
                        fault = STAT_MISALIGNED;
                end
            end
            3: sect_tsid[15:8] = r.data_byte;
            4: sect_tsid[7:0] = r.data_byte;
            5:
            begin
                sect_ver = r.data_byte[5:1];
                sect_cur = r.data_byte[0];
            end
            6, 7:
            begin
                if (r.data_byte != 0 && (fault == STAT_COMMITTED || fault == STAT_MISALIGNED))
                    fault = STAT_MULTI_SECT;
            end
            default:
            begin
                if (fault != STAT_BAD_HEADER)
                begin
                    total = int'(sect_len) + 3;
                    if (idx + 4 < total)
                    begin
                        if (((idx - 8) & 3) == 3)
                        begin
                            pn = entry_bytes[23:8];
                            epid = {entry_bytes[4:0], r.data_byte};
                            if (fault == STAT_COMMITTED && !r.last)
                            begin
                                o.kind = (pn == 0) ? KIND_NIT : KIND_PROGRAM;
                                o.prog_num = pn;
                                o.pid = epid;
                                emit = 1;
                            end
                            if (pn != 0)
                            begin
                                if (staged_cnt < 256)
                                    staged_tbl[staged_cnt] = {pn, epid};
                                if (staged_cnt < 511)
                                    staged_cnt++;
                            end
                            entry_bytes = '0;
                        end
                        else
                            entry_bytes = {entry_bytes[15:0], r.data_byte};
                    end
                    else if (idx < total)
                        crc_bytes = {crc_bytes[23:0], r.data_byte};
                end
            end
        endcase
        if (r.last)
        begin
            o = '0;
            o.kind = KIND_DONE;
            o.stream_id = sect_tsid;
            o.version = sect_ver;
            o.program_count = staged_cnt[7:0];
            o.crc_word = crc_bytes;
            o.status = section_verdict(idx + 1);
            reset_section();
            emit = 1;
        end
        if (emit)
            expected_rsps.push_back(o);
    endtask

    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(negedge clk);
        while (req_stall)
            @(negedge clk);
        @(posedge clk);
        predict_request(r);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        req_t r;
        r = '0;
        r.data_byte = b;
        r.last = is_last;
        r.query_pid = 13'($urandom);
        send_request(r);
    endtask

    task automatic send_query(input logic [12:0] qpid);
        req_t r;
        r = '0;
        r.mode = 1'b1;
        r.data_byte = 8'($urandom);
        r.last = 1'($urandom);
        r.query_pid = qpid;
        send_request(r);
    endtask

    task automatic send_section(input logic [7:0] bytes[$]);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    function automatic void build_pat(output logic [7:0] s[$], input int n_entries,
                                      input logic [4:0] ver, input logic cur,
                                      input bit pid_pool);
        int len;
        len = 9 + 4 * n_entries;
        s = {};
        s.push_back(8'h00);
        s.push_back({4'hB, 4'(len >> 8)});
        s.push_back(8'(len));
        s.push_back(8'($urandom));
        s.push_back(8'($urandom));
        s.push_back({2'b11, ver, cur});
        s.push_back(8'h00);
        s.push_back(8'h00);
        for (int i = 0; i < n_entries; i++)
        begin
            logic [15:0] pn;
            logic [12:0] p;
            pn = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
            p = pid_pool ? 13'($urandom_range(63)) : 13'($urandom);
            s.push_back(pn[15:8]);
            s.push_back(pn[7:0]);
            s.push_back({3'($urandom), p[12:8]});
            s.push_back(p[7:0]);
        end
        repeat (4) s.push_back(8'($urandom));
    endfunction

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stuck_cycles <= 0;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles > WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("response with none expected: kind %0d", rsp.kind);
                    failures++;
                end
                else
                begin
                    rsp_t e;
                    e = expected_rsps.pop_front();
                    if (rsp.kind !== e.kind)
                        begin $error("kind exp %0d got %0d", e.kind, rsp.kind); failures++; end
                    if (rsp.prog_num !== e.prog_num)
                        begin $error("prog_num exp %0d got %0d", e.prog_num,
                            rsp.prog_num); failures++; end
                    if (rsp.pid !== e.pid)
                        begin $error("pid exp %0d got %0d", e.pid, rsp.pid); failures++; end
                    if (rsp.status !== e.status)
                        begin $error("status exp %0d got %0d", e.status, rsp.status);
                            failures++; end
                    if (rsp.stream_id !== e.stream_id)
                        begin $error("stream_id exp %0d got %0d", e.stream_id, rsp.stream_id);
                            failures++; end
                    if (rsp.version !== e.version)
                        begin $error("version exp %0d got %0d", e.version, rsp.version);
                            failures++; end
                    if (rsp.program_count !== e.program_count)
                        begin $error("program_count exp %0d got %0d", e.program_count,
                            rsp.program_count); failures++; end
                    if (rsp.crc_word !== e.crc_word)
                        begin $error("crc_word exp %h got %h", e.crc_word, rsp.crc_word);
                            failures++; end
                    if (rsp.pid_class !== e.pid_class)
                        begin $error("pid_class exp %0d got %0d", e.pid_class, rsp.pid_class);
                            failures++; end
                end
            end
        end
    end

    task automatic test_directed();
        logic [7:0] s[$];
        build_pat(s, 3, 5'd1, 1'b1, 0);
        s[8] = 8'hFF; s[9] = 8'hFF; s[10] = 8'hFF; s[11] = 8'hFF;
        send_section(s);
        send_query({s[10][4:0], s[11]});
        send_section(s);
        build_pat(s, 1, 5'd31, 1'b0, 0);
        send_section(s);
        send_section('{8'h02, 8'hB0, 8'h09});
        send_section('{8'h00, 8'h30});
        send_section('{8'h00, 8'hB0, 8'h0A, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00});
        send_section('{8'h00, 8'hBF, 8'hFF});
        send_section('{8'h00});
        build_pat(s, 2, 5'd3, 1'b1, 0);
        s[6] = 8'h01;
        send_section(s);
        build_pat(s, 2, 5'd4, 1'b1, 0);
        void'(s.pop_back());
        send_section(s);
        send_query(13'h1FFF);
        send_query(13'h0000);
    endtask

    task automatic test_large_table();
        logic [7:0] s[$];
        build_pat(s, 100, 5'd9, 1'b1, 0);
        repeat (3) s.push_back(8'($urandom));
        send_section(s);
        send_query(13'($urandom));
        wait_drained();
    endtask

    task automatic test_random(input int n_items);
        logic [7:0] s[$];
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            int pick;
            pick = $urandom_range(9);
            if (pick < 6)
            begin
                build_pat(s, $urandom_range(6), 5'($urandom_range(3)),
                          1'($urandom_range(5) != 0), 1);
                if ($urandom_range(5) == 0)
                    s[$urandom_range(s.size() - 1)] = 8'($urandom);
                if ($urandom_range(7) == 0)
                    s = s[0:$urandom_range(s.size() - 1)];
                send_section(s);
                sent += s.size();
            end
            else if (pick < 9)
            begin
                send_query(($urandom_range(1)) ? 13'($urandom_range(63)) : 13'($urandom));
                sent++;
            end
            else
            begin
                int n;
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom), i == n - 1);
                sent += n;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 8192; i++)
            class_map[i] = CLASS_UNKNOWN;
        active_cnt = 0;
        table_held = 0;
        active_ver = '0;
        reset_section();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_large_table();
        send_idle_pct = 34;
        recv_idle_pct = 87;
        test_random(100);
        send_idle_pct = 87;
        recv_idle_pct = 34;
        test_random(100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(110);
        if (failures == 0 && expected_rsps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
